// File: rtl/core/ovce_pkg.sv
// Package for the Ogg Vorbis comment extractor core.
// Holds payload structs, phase enum, result kinds and status codes. No dependencies.
`timescale 1ns / 1ps
package ovce_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  item_kind;
      logic [7:0]  out_byte;
      logic [1:0]  field_class;
      logic [3:0]  status;
      logic [16:0] audio_start;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_HDR, PH_SEG, PH_IDENT, PH_CHDR, PH_VLEN, PH_VENDOR,
      PH_COUNT, PH_CLEN, PH_COMMENT, PH_SKIP, PH_IDLE
   } phase_type;

   localparam logic [2:0] KIND_VENDOR = 3'd0;
   localparam logic [2:0] KIND_KEY    = 3'd1;
   localparam logic [2:0] KIND_VALUE  = 3'd2;
   localparam logic [2:0] KIND_END    = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;

   localparam logic [1:0] CLASS_VENDOR = 2'd0;
   localparam logic [1:0] CLASS_VALID  = 2'd1;
   localparam logic [1:0] CLASS_DROP   = 2'd2;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_SHORT     = 4'd1;
   localparam logic [3:0] ST_SYNC      = 4'd2;
   localparam logic [3:0] ST_VERSION   = 4'd3;
   localparam logic [3:0] ST_NOSEG     = 4'd4;
   localparam logic [3:0] ST_SEGTAB    = 4'd5;
   localparam logic [3:0] ST_PACKETS   = 4'd6;
   localparam logic [3:0] ST_IDENT_LEN = 4'd7;
   localparam logic [3:0] ST_IDENT_HDR = 4'd8;
   localparam logic [3:0] ST_COMM_LEN  = 4'd9;
   localparam logic [3:0] ST_COMM_HDR  = 4'd10;
   localparam logic [3:0] ST_VENDOR    = 4'd11;
   localparam logic [3:0] ST_COUNT     = 4'd12;

   localparam logic [0:0] CSR_CHUNK_LENGTH = 1'd0;

   function automatic logic [7:0] sync_char(input logic [1:0] i);
      case (i)
         2'd0: sync_char = 8'h4F;
         2'd1: sync_char = 8'h67;
         2'd2: sync_char = 8'h67;
         default: sync_char = 8'h53;
      endcase
   endfunction

   function automatic logic [7:0] magic_char(input logic [2:0] i);
      case (i)
         3'd0: magic_char = 8'h76;
         3'd1: magic_char = 8'h6F;
         3'd2: magic_char = 8'h72;
         3'd3: magic_char = 8'h62;
         3'd4: magic_char = 8'h69;
         3'd5: magic_char = 8'h73;
         default: magic_char = 8'h00;
      endcase
   endfunction

endpackage

// File: rtl/core/ovce_parser.sv
// Parser step for the Ogg Vorbis comment extractor: state registers and the
// per-byte next-state and result logic. Uses ovce_pkg.
`timescale 1ns / 1ps
module ovce_parser #(
   parameter int CHUNK_MAX = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  ovce_pkg::req_type   req,
   input  logic [16:0]         chunk_length,
   output ovce_pkg::rsp_type   res [3],
   output logic [1:0]          res_count
);

   localparam logic [17:0] MAX18 = (CHUNK_MAX > 131071) ? 18'd131071 : 18'(CHUNK_MAX);

   ovce_pkg::phase_type phase_ff, phase_in;
   logic [16:0] offset_ff, offset_in;
   logic [7:0]  seg_total_ff, seg_total_in, seg_index_ff, seg_index_in;
   logic [16:0] lacing_ff, lacing_in;
   logic [1:0]  packets_ff, packets_in;
   logic [16:0] ident_len_ff, ident_len_in, cpl_ff, cpl_in, pos_ff, pos_in;
   logic [31:0] remain_ff, remain_in, left_ff, left_in, word_ff, word_in;
   logic        eq_ff, eq_in;

   logic [17:0] len;
   assign len = ({1'b0, chunk_length} > MAX18) ? MAX18 : {1'b0, chunk_length};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ovce_pkg::PH_HDR;
         offset_ff <= '0; seg_total_ff <= '0; seg_index_ff <= '0; lacing_ff <= '0;
         packets_ff <= '0; ident_len_ff <= '0; cpl_ff <= '0; pos_ff <= '0;
         remain_ff <= '0; left_ff <= '0; word_ff <= '0; eq_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         offset_ff <= offset_in; seg_total_ff <= seg_total_in;
         seg_index_ff <= seg_index_in; lacing_ff <= lacing_in;
         packets_ff <= packets_in; ident_len_ff <= ident_len_in; cpl_ff <= cpl_in;
         pos_ff <= pos_in; remain_ff <= remain_in; left_ff <= left_in;
         word_ff <= word_in; eq_ff <= eq_in;
      end
   end

   always_comb begin
      ovce_pkg::phase_type ph;
      logic [16:0] off, pos, lac;
      logic [7:0]  b, sidx;
      logic [1:0]  pk, n;
      logic [31:0] w, room, rem1;
      logic [18:0] sum;
      logic        stop, pend;
      ovce_pkg::rsp_type r [3];
      ovce_pkg::rsp_type z;

      b = req.data_byte;
      z = '0;
      r[0] = z; r[1] = z; r[2] = z;
      n = 2'd0;
      stop = 1'b0;
      ph = phase_ff;
      offset_in = offset_ff; seg_total_in = seg_total_ff; seg_index_in = seg_index_ff;
      lacing_in = lacing_ff; packets_in = packets_ff; ident_len_in = ident_len_ff;
      cpl_in = cpl_ff; pos_in = pos_ff; remain_in = remain_ff; left_in = left_ff;
      word_in = word_ff; eq_in = eq_ff;
      if (req.chunk_start) begin
         ph = ovce_pkg::PH_HDR;
         offset_in = '0; seg_total_in = '0; seg_index_in = '0; lacing_in = '0;
         packets_in = '0; ident_len_in = '0; cpl_in = '0; pos_in = '0;
         remain_in = '0; left_in = '0; word_in = '0; eq_in = 1'b0;
      end
      off = offset_in;
      pos = pos_in;
      w = {b, word_in[31:8]};
      rem1 = remain_in - 32'd1;
      room = {15'd0, cpl_in - (pos + 17'd1)};
      sum = '0; lac = '0; sidx = '0; pk = '0; pend = 1'b0;
      if (ph != ovce_pkg::PH_IDLE) begin
         offset_in = off + 17'd1;
         case (ph)
            ovce_pkg::PH_HDR: begin
               if (off == 17'd0 && len < 18'd27) begin
                  r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                  r[n].status = ovce_pkg::ST_SHORT; n = n + 2'd1; stop = 1'b1;
               end else if (off < 17'd4) begin
                  if (b != ovce_pkg::sync_char(off[1:0])) begin
                     r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                     r[n].status = ovce_pkg::ST_SYNC; n = n + 2'd1; stop = 1'b1;
                  end
               end else if (off == 17'd4) begin
                  if (b != 8'd0) begin
                     r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                     r[n].status = ovce_pkg::ST_VERSION; n = n + 2'd1; stop = 1'b1;
                  end
               end else if (off == 17'd26) begin
                  seg_total_in = b;
                  if (b == 8'd0) begin
                     r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                     r[n].status = ovce_pkg::ST_NOSEG; n = n + 2'd1; stop = 1'b1;
                  end else if (18'd27 + {10'd0, b} > len) begin
                     r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                     r[n].status = ovce_pkg::ST_SEGTAB; n = n + 2'd1; stop = 1'b1;
                  end else begin
                     ph = ovce_pkg::PH_SEG; seg_index_in = '0; lacing_in = '0;
                     packets_in = '0;
                  end
               end
            end
            ovce_pkg::PH_SEG: begin
               lac = lacing_in + {9'd0, b};
               sidx = seg_index_in + 8'd1;
               seg_index_in = sidx;
               lacing_in = lac;
               pk = packets_in;
               if (b < 8'd255 || sidx >= seg_total_in) begin
                  if (pk == 2'd0) ident_len_in = lac;
                  else if (pk == 2'd1) cpl_in = lac;
                  if (pk < 2'd2) pk = pk + 2'd1;
                  packets_in = pk;
                  lacing_in = '0;
               end
               sum = {2'd0, off} + 19'd1 + {2'd0, ident_len_in};
               if (sidx >= seg_total_in) begin
                  r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE; stop = 1'b1;
                  if (pk < 2'd2) r[n].status = ovce_pkg::ST_PACKETS;
                  else if (sum > {1'b0, len}) r[n].status = ovce_pkg::ST_IDENT_LEN;
                  else if (ident_len_in < 17'd7) r[n].status = ovce_pkg::ST_IDENT_HDR;
                  else begin
                     stop = 1'b0; ph = ovce_pkg::PH_IDENT; pos_in = '0;
                  end
                  if (stop) n = n + 2'd1;
               end
            end
            ovce_pkg::PH_IDENT: begin
               pos_in = pos + 17'd1;
               if ((pos == 17'd0 && b != 8'd1) ||
                   (pos != 17'd0 && pos <= 17'd6 &&
                    b != ovce_pkg::magic_char(3'(pos - 17'd1)))) begin
                  r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                  r[n].status = ovce_pkg::ST_IDENT_HDR; n = n + 2'd1; stop = 1'b1;
               end else begin
                  sum = {2'd0, off} + {2'd0, ident_len_in - 17'd6} + {2'd0, cpl_in};
                  if (pos == 17'd6 && sum > {1'b0, len}) begin
                     r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                     r[n].status = ovce_pkg::ST_COMM_LEN; n = n + 2'd1; stop = 1'b1;
                  end else if (pos == 17'd6 && cpl_in < 17'd7) begin
                     r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                     r[n].status = ovce_pkg::ST_COMM_HDR; n = n + 2'd1; stop = 1'b1;
                  end else if (pos_in >= ident_len_in) begin
                     ph = ovce_pkg::PH_CHDR; pos_in = '0;
                  end
               end
            end
            default: begin
               pos_in = pos + 17'd1;
               case (ph)
                  ovce_pkg::PH_CHDR: begin
                     // The phase ends at position six, so only the six magic
                     // bytes after the type byte are ever checked here.
                     if ((pos == 17'd0 && b != 8'd3) ||
                         (pos != 17'd0 &&
                          b != ovce_pkg::magic_char(3'(pos - 17'd1)))) begin
                        r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                        r[n].status = ovce_pkg::ST_COMM_HDR; n = n + 2'd1; stop = 1'b1;
                     end else if (pos == 17'd6) begin
                        if (cpl_in < 17'd11) begin
                           r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                           r[n].status = ovce_pkg::ST_VENDOR; n = n + 2'd1;
                           stop = 1'b1;
                        end else begin
                           ph = ovce_pkg::PH_VLEN; remain_in = 32'd4; word_in = '0;
                        end
                     end
                  end
                  ovce_pkg::PH_VLEN: begin
                     word_in = w; remain_in = rem1;
                     if (rem1 == 32'd0) begin
                        if (w > room) begin
                           r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                           r[n].status = ovce_pkg::ST_VENDOR; n = n + 2'd1;
                           stop = 1'b1;
                        end else if (w != 32'd0) begin
                           ph = ovce_pkg::PH_VENDOR; remain_in = w;
                        end else pend = 1'b1;
                     end
                  end
                  ovce_pkg::PH_VENDOR: begin
                     r[n] = z; r[n].item_kind = ovce_pkg::KIND_VENDOR; r[n].out_byte = b;
                     n = n + 2'd1;
                     remain_in = rem1;
                     if (rem1 == 32'd0) begin
                        r[n] = z; r[n].item_kind = ovce_pkg::KIND_END;
                        r[n].field_class = ovce_pkg::CLASS_VENDOR; n = n + 2'd1;
                        pend = 1'b1;
                     end
                  end
                  ovce_pkg::PH_COUNT: begin
                     word_in = w; remain_in = rem1;
                     if (rem1 == 32'd0) begin
                        left_in = w;
                        if (w == 32'd0 || room < 32'd4) ph = ovce_pkg::PH_SKIP;
                        else begin ph = ovce_pkg::PH_CLEN; remain_in = 32'd4; word_in = '0; end
                     end
                  end
                  ovce_pkg::PH_CLEN: begin
                     word_in = w; remain_in = rem1;
                     if (rem1 == 32'd0) begin
                        left_in = left_in - 32'd1;
                        if (w > room) ph = ovce_pkg::PH_SKIP;
                        else if (w == 32'd0) begin
                           r[n] = z; r[n].item_kind = ovce_pkg::KIND_END;
                           r[n].field_class = ovce_pkg::CLASS_DROP; n = n + 2'd1;
                           if (left_in == 32'd0 || room < 32'd4) ph = ovce_pkg::PH_SKIP;
                           else begin
                              ph = ovce_pkg::PH_CLEN; remain_in = 32'd4; word_in = '0;
                           end
                        end else begin
                           ph = ovce_pkg::PH_COMMENT; remain_in = w; eq_in = 1'b0;
                        end
                     end
                  end
                  ovce_pkg::PH_COMMENT: begin
                     if (!eq_in && b == 8'h3D) eq_in = 1'b1;
                     else begin
                        r[n] = z;
                        r[n].item_kind = eq_in ? ovce_pkg::KIND_VALUE : ovce_pkg::KIND_KEY;
                        r[n].out_byte = b; n = n + 2'd1;
                     end
                     remain_in = rem1;
                     if (rem1 == 32'd0) begin
                        r[n] = z; r[n].item_kind = ovce_pkg::KIND_END;
                        r[n].field_class = eq_in ? ovce_pkg::CLASS_VALID
                                                 : ovce_pkg::CLASS_DROP;
                        n = n + 2'd1;
                        if (left_in == 32'd0 || room < 32'd4) ph = ovce_pkg::PH_SKIP;
                        else begin
                           ph = ovce_pkg::PH_CLEN; remain_in = 32'd4; word_in = '0;
                        end
                     end
                  end
                  default: ;
               endcase
               // Start of the comment count after the vendor string.
               if (pend) begin
                  if (room < 32'd4) begin
                     r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                     r[n].status = ovce_pkg::ST_COUNT; n = n + 2'd1; stop = 1'b1;
                  end else begin
                     ph = ovce_pkg::PH_COUNT; remain_in = 32'd4; word_in = '0;
                  end
               end
               if (!stop && pos_in >= cpl_in) begin
                  r[n] = z; r[n].item_kind = ovce_pkg::KIND_DONE;
                  r[n].audio_start = off + 17'd1; n = n + 2'd1; stop = 1'b1;
               end
            end
         endcase
      end
      if (stop) ph = ovce_pkg::PH_IDLE;
      phase_in = ph;
      if (n != 2'd0) r[n - 2'd1].last_of_run = 1'b1;
      res = r;
      res_count = n;
   end

endmodule

// File: rtl/core/ovce_out_queue.sv
// Result queue for the comment extractor: takes up to three results per
// transfer and delivers them one by one. Uses ovce_pkg.
`timescale 1ns / 1ps
module ovce_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ovce_pkg::rsp_type push_item [3],
   input  logic [1:0]        push_count,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ovce_pkg::rsp_type rsp_data
);

   ovce_pkg::rsp_type slot_ff [8];
   logic [2:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [3:0] cnt_ff, cnt_in;
   logic pop;

   assign rsp_valid = cnt_ff != 4'd0;
   assign rsp_data = slot_ff[rd_ff];
   assign pop = rsp_valid && !rsp_stall;
   // Room for a full run of three results must remain.
   assign space = cnt_ff <= 4'd5;

   always_comb begin
      rd_in = pop ? rd_ff + 3'd1 : rd_ff;
      wr_in = push ? wr_ff + 3'(push_count) : wr_ff;
      cnt_in = cnt_ff + (push ? {2'd0, push_count} : 4'd0) - {3'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < push_count) slot_ff[wr_ff + 3'(i)] <= push_item[i];
         end
      end
   end

endmodule

// File: rtl/core/ogg_vorbis_comment_extractor_core.sv
// Top level of the Ogg Vorbis comment extractor core.
// Instantiates ovce_parser and ovce_out_queue; uses ovce_pkg.
`timescale 1ns / 1ps
// How to use the block:
// Stream bytes of the first chunk of an Ogg stream on the req_ channel, one
// byte per transfer, with chunk_start set on the first byte. Before that,
// write chunk_length through the APB port at address 0 while idle.
// The block checks the page header and the identification and comment
// headers, and sends vendor bytes, key bytes, value bytes, field ends and a
// final done item on the rsp_ channel. Each byte causes zero to three
// results; the last of them carries last_of_run.
// Throughput is one byte per cycle while the queue has room: the parser is a
// single registered step per byte. A byte's results are written into an
// eight-entry result queue at the edge of the transfer and can leave in the
// next cycle, one per cycle while rsp_stall is low. Since a byte can cause up
// to three results, the queue stalls req_ when fewer than three entries are
// free; sustained rate is then set by the rsp_ side, one result per cycle.
// When the receiver stalls, the queue holds its data and the head result
// stays steady on rsp_data. Reset empties the queue, clears chunk_length
// and puts the parser at offset zero of the page header.
module ogg_vorbis_comment_extractor_core #(
   parameter int CHUNK_MAX = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ovce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ovce_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [0:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [16:0] chunk_length_ff;
   logic space, step;
   ovce_pkg::rsp_type res [3];
   logic [1:0] res_count;

   // Byte address 0 holds the only register; paddr carries word bit 2 only.
   assign pready = 1'b1;
   assign prdata = (paddr == ovce_pkg::CSR_CHUNK_LENGTH) ? {15'd0, chunk_length_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) chunk_length_ff <= '0;
      else if (psel && penable && pwrite && paddr == ovce_pkg::CSR_CHUNK_LENGTH)
         chunk_length_ff <= pwdata[16:0];
   end

   assign req_stall = !space;
   assign step = req_valid && space;

   ovce_parser #(.CHUNK_MAX(CHUNK_MAX)) u_parser (
      .clock(clock), .reset(reset), .step(step), .req(req_data),
      .chunk_length(chunk_length_ff), .res(res), .res_count(res_count)
   );

   ovce_out_queue u_queue (
      .clock(clock), .reset(reset), .push(step), .push_item(res),
      .push_count(res_count), .space(space), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule
